// ===== rtl/srt_pkg.sv =====
// srt_pkg: shared types and codes of the sorted record table
package srt_pkg;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_REMOVED   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic               action;
      logic signed [31:0] key;
      logic [63:0]        name_chars;
      logic [31:0]        salary_bits;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] entries_held;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [63:0]        name_chars;
      logic [31:0]        salary_bits;
   } rec_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic compare;
      logic do_insert;
      logic do_delete;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_COMPARE,
      SEQ_DECIDE,
      SEQ_APPLY
   } seq_state_type;

endpackage

// ===== rtl/srt_cell.sv =====
// srt_cell: one table slot with its key compare and neighbor shift
module srt_cell (
   input  logic                  clock,
   input  srt_pkg::cell_ctrl_type ctrl,
   input  srt_pkg::rec_type      new_rec,
   input  srt_pkg::rec_type      left_rec,
   input  srt_pkg::rec_type      right_rec,
   input  logic                  left_after,
   input  logic                  occupied,
   output srt_pkg::rec_type      rec,
   output logic                  after,
   output logic                  hit
);
   import srt_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;
   logic    after_ff;
   logic    ge_ff;
   logic    hit_ff;

   // insert: open a gap above every smaller or equal key
   // delete: close the gap from the first key not below the target
   always_comb begin
      rec_in = rec_ff;
      if (ctrl.do_insert && after_ff) begin
         rec_in = left_after ? left_rec : new_rec;
      end else if (ctrl.do_delete && ge_ff) begin
         rec_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (ctrl.compare) begin
         after_ff <= !occupied || (rec_ff.key > new_rec.key);
         ge_ff    <= occupied && (rec_ff.key >= new_rec.key);
         hit_ff   <= occupied && (rec_ff.key == new_rec.key);
      end
   end

   assign rec   = rec_ff;
   assign after = after_ff;
   assign hit   = hit_ff;

endmodule

// ===== rtl/sorted_record_table.sv =====
// sorted_record_table: bounded key-ordered record table built as a chain of cells
//
//   channel | direction | ports                          | payload
//   --------+-----------+--------------------------------+---------------------------
//   request | in        | req_valid, req_stall, req_data | action, key, name, salary
//   result  | out       | rsp_valid, rsp_stall, rsp_data | status, entries_held
//
// each item passes through four steps: accept, compare in every cell, reduce the
// delete hit flags, then shift the chain and register the result
// the result register frees the request side: a new item is taken while a
// finished result still waits, and the shift step waits for a free slot
// reset clears only the sequencer, fill count and result valid; slot
// contents are never read above the fill count
module sorted_record_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srt_pkg::rsp_type rsp_data
);
   import srt_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   seq_state_type state_ff, state_in;
   req_type       op_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic          hit_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   cell_ctrl_type ctrl;
   rec_type       new_rec;
   logic          accept;
   logic          fire;
   logic          table_full;

   // per-cell wiring of the chain
   rec_type             rec_vec   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] after_vec;
   logic [TABLE_DEPTH-1:0] hit_vec;
   logic [TABLE_DEPTH-1:0] occ_vec;

   assign new_rec.key         = op_ff.key;
   assign new_rec.name_chars  = op_ff.name_chars;
   assign new_rec.salary_bits = op_ff.salary_bits;

   assign table_full = (fill_ff == FULL_COUNT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE:    if (req_valid) state_in = SEQ_COMPARE;
         SEQ_COMPARE: state_in = SEQ_DECIDE;
         SEQ_DECIDE:  state_in = SEQ_APPLY;
         SEQ_APPLY:   if (!rsp_valid_ff || !rsp_stall) state_in = SEQ_IDLE;
         default:     state_in = SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall      = 1'b1;
      ctrl.compare   = 1'b0;
      fire           = 1'b0;
      case (state_ff)
         SEQ_IDLE:    req_stall = 1'b0;
         SEQ_COMPARE: ctrl.compare = 1'b1;
         SEQ_DECIDE:  ;
         SEQ_APPLY:   fire = !rsp_valid_ff || !rsp_stall;
         default:     ;
      endcase
      ctrl.do_insert = fire && (op_ff.action == ACT_INSERT) && !table_full;
      ctrl.do_delete = fire && (op_ff.action == ACT_DELETE) && hit_ff;
   end

   assign accept = req_valid && !req_stall;

   // fill count and result
   always_comb begin
      fill_in      = fill_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) rsp_valid_in = 1'b0;
      if (ctrl.do_insert) fill_in = fill_ff + 1'b1;
      if (ctrl.do_delete) fill_in = fill_ff - 1'b1;
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (op_ff.action == ACT_INSERT) begin
            rsp_in.status = table_full ? ST_FULL : ST_INSERTED;
         end else begin
            rsp_in.status = hit_ff ? ST_REMOVED : ST_NOT_FOUND;
         end
         // count is reported modulo 32
         rsp_in.entries_held = 5'(fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) op_ff <= req_data;
      // any occupied cell holding the key makes the delete a hit
      if (state_ff == SEQ_DECIDE) hit_ff <= |hit_vec;
      rsp_ff <= rsp_in;
   end

   genvar i;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         localparam logic [CW-1:0] IDX = CW'(i);
         rec_type left_rec;
         rec_type right_rec;
         logic    left_after;

         assign occ_vec[i] = fill_ff > IDX;

         // cell zero has no left neighbor: when an insert moves it, it takes the new record
         if (i == 0) begin : g_first
            assign left_rec   = new_rec;
            assign left_after = 1'b0;
         end else begin : g_inner
            assign left_rec   = rec_vec[i-1];
            assign left_after = after_vec[i-1];
         end

         // the top cell keeps its own contents when the chain closes up
         if (i == TABLE_DEPTH - 1) begin : g_last
            assign right_rec = rec_vec[i];
         end else begin : g_below
            assign right_rec = rec_vec[i+1];
         end

         srt_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .new_rec    (new_rec),
            .left_rec   (left_rec),
            .right_rec  (right_rec),
            .left_after (left_after),
            .occupied   (occ_vec[i]),
            .rec        (rec_vec[i]),
            .after      (after_vec[i]),
            .hit        (hit_vec[i])
         );
      end
   endgenerate

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
